// ----- rtl/core/tfn_pkg.sv -----
package tfn_pkg;

    localparam int UNIT_W  = 16;                      // Q1.14 result component
    localparam int NORM_W  = 30;                      // normalized cross magnitude
    localparam int SQ_W    = 2 * NORM_W + 2;          // sum of three squares
    localparam int ROOT_W  = 31;                      // floor(sqrt(sum))
    localparam int REM_W   = ROOT_W + 4;              // square root partial remainder
    localparam int FRAC_SH = 15;                      // 2^14 scale plus half-unit rounding
    localparam int NUM_W   = NORM_W + FRAC_SH + 1;    // (a << 15) + r
    localparam int D_W     = ROOT_W + 1;              // 2 * r
    localparam int QUO_W   = UNIT_W - 1;              // quotient magnitude, up to 16384
    localparam int GRP_W   = 8;                       // leading-zero search group
    localparam int GLZ_W   = $clog2(GRP_W);

    typedef logic [2:0][NORM_W-1:0] norm_vec_t;

    typedef struct packed {
        logic       vld;
        logic       degen;
        logic [2:0] neg;
    } tfn_ctl_t;

endpackage

// ----- rtl/core/triangle_face_normal.sv -----
// Pipeline: 57 register stages; a triangle that first sat in the skid register enters
// them once the pipe advances again. Throughput: one triangle per cycle while the
// output word is not held off, set by a fully pipelined datapath (one root bit per
// stage in the square root, one quotient bit per stage in the dividers).
// Reset: rst_n clears every valid bit, the skid flag included; data registers keep junk.
module triangle_face_normal
    import tfn_pkg::*;
#(
    parameter int COORD_WIDTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          tri_valid,
    output logic                          tri_stall,
    input  logic signed [COORD_WIDTH-1:0] a_x,
    input  logic signed [COORD_WIDTH-1:0] a_y,
    input  logic signed [COORD_WIDTH-1:0] a_z,
    input  logic signed [COORD_WIDTH-1:0] b_x,
    input  logic signed [COORD_WIDTH-1:0] b_y,
    input  logic signed [COORD_WIDTH-1:0] b_z,
    input  logic signed [COORD_WIDTH-1:0] c_x,
    input  logic signed [COORD_WIDTH-1:0] c_y,
    input  logic signed [COORD_WIDTH-1:0] c_z,
    output logic                          norm_valid,
    input  logic                          norm_stall,
    output logic signed [UNIT_W-1:0]      unit_x,
    output logic signed [UNIT_W-1:0]      unit_y,
    output logic signed [UNIT_W-1:0]      unit_z,
    output logic                          degenerate
);

    // Datapath outline:
    //   tfn_norm : edges, six products, cross product, magnitudes, two-step leading
    //              zero search, normalizing shift to 30 bits, squares, sum (9 stages)
    //   tfn_sqrt : restoring square root, one root bit per stage (31 stages)
    //   tfn_div  : setup, three restoring dividers in lockstep, sign and degenerate
    //              zeroing into the output register (17 stages)
    //
    // The whole pipe moves on one enable: it freezes only while the output word is
    // held off. The skid register catches the one triangle that arrives in the cycle
    // the pipe freezes, so tri_stall is a flop and never waits on norm_stall.

    logic                         skid_vld_reg, skid_vld_next;
    logic [8:0][COORD_WIDTH-1:0]  skid_reg;
    logic [8:0][COORD_WIDTH-1:0]  pts_in;
    logic [8:0][COORD_WIDTH-1:0]  pts_sel;
    logic                         take;
    logic                         adv;
    logic                         entry_vld;

    tfn_ctl_t                     norm_ctl;
    logic [SQ_W-1:0]              sum_sq;
    norm_vec_t                    norm_mag;
    tfn_ctl_t                     root_ctl;
    logic [ROOT_W-1:0]            root;
    norm_vec_t                    root_mag;
    logic [2:0][UNIT_W-1:0]       unit;

    assign pts_in = {c_z, c_y, c_x, b_z, b_y, b_x, a_z, a_y, a_x};

    assign tri_stall = skid_vld_reg;
    assign take      = tri_valid & ~skid_vld_reg;
    // advance whenever the output register is empty or being drained
    assign adv       = ~norm_valid | ~norm_stall;

    // the held word goes first; a fresh word bypasses the skid when the pipe moves
    assign pts_sel   = skid_vld_reg ? skid_reg : pts_in;
    assign entry_vld = skid_vld_reg | take;

    always_comb
    begin
        if (adv)
        begin
            skid_vld_next = 1'b0;
        end
        else
        begin
            skid_vld_next = skid_vld_reg | take;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && !adv)
        begin
            skid_reg <= pts_in;
        end
    end

    tfn_norm #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .entry_vld (entry_vld),
        .pts       (pts_sel),
        .ctl       (norm_ctl),
        .sum_sq    (sum_sq),
        .mag       (norm_mag)
    );

    tfn_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .ctl_in  (norm_ctl),
        .sum_sq  (sum_sq),
        .mag_in  (norm_mag),
        .ctl_out (root_ctl),
        .root    (root),
        .mag_out (root_mag)
    );

    tfn_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .ctl_in  (root_ctl),
        .root    (root),
        .mag_in  (root_mag),
        .res_vld (norm_valid),
        .unit    (unit),
        .degen   (degenerate)
    );

    assign unit_x = $signed(unit[0]);
    assign unit_y = $signed(unit[1]);
    assign unit_z = $signed(unit[2]);

`ifndef SYNTH
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        norm_valid && degenerate |-> unit_x == 16'sd0 && unit_y == 16'sd0 && unit_z == 16'sd0)
        else $error("degenerate word carries nonzero components");

    a_live_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        norm_valid && !degenerate |-> unit_x != 16'sd0 || unit_y != 16'sd0 || unit_z != 16'sd0)
        else $error("non-degenerate word has all components zero");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        norm_valid |-> unit_x >= -16'sd16384 && unit_x <= 16'sd16384
                    && unit_y >= -16'sd16384 && unit_y <= 16'sd16384
                    && unit_z >= -16'sd16384 && unit_z <= 16'sd16384)
        else $error("normal component outside Q1.14 unit range");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg && adv |=> !skid_vld_reg)
        else $error("skid register not drained when the pipe advanced");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_vld_reg) |-> $past(!adv) && $past(take))
        else $error("skid register filled without a frozen pipe and an accepted word");
`endif

endmodule

// ----- rtl/core/tfn_norm.sv -----
module tfn_norm
    import tfn_pkg::*;
#(
    parameter int COORD_WIDTH = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         entry_vld,
    input  logic [8:0][COORD_WIDTH-1:0]  pts,
    output tfn_ctl_t                     ctl,
    output logic [SQ_W-1:0]              sum_sq,
    output norm_vec_t                    mag
);

    localparam int EW    = (COORD_WIDTH > 29) ? 30 : COORD_WIDTH + 1;
    localparam int ESH   = (COORD_WIDTH > 29) ? COORD_WIDTH - 29 : 0;
    localparam int PW    = 2 * EW;
    localparam int NW    = 2 * EW + 1;
    localparam int MW    = 2 * EW;
    localparam int GRPS  = (MW + GRP_W - 1) / GRP_W;
    localparam int PADW  = GRPS * GRP_W;
    localparam int LZW   = $clog2(PADW);
    localparam int NSTG  = 9;

    function automatic logic [GLZ_W-1:0] grp_lzc(input logic [GRP_W-1:0] v);
        logic [GLZ_W-1:0] n;
        n = GLZ_W'(GRP_W - 1);
        for (int b = 0; b < GRP_W; b++) begin
            if (v[b])
            begin
                n = GLZ_W'(GRP_W - 1 - b);
            end
        end
        return n;
    endfunction

    logic [NSTG-1:0] vld_reg;

    // stage 1: edges
    logic signed [EW-1:0]  e1_reg [3], e1_next [3];
    logic signed [EW-1:0]  e2_reg [3], e2_next [3];
    logic signed [COORD_WIDTH:0] d1, d2;
    // stage 2: partial products
    logic signed [PW-1:0]  prod_reg [6], prod_next [6];
    // stage 3: cross product
    logic signed [NW-1:0]  crs_reg [3], crs_next [3];
    // stage 4: magnitudes
    logic [MW-1:0]         mg4_reg [3], mg4_next [3];
    logic [2:0]            neg4_reg, neg4_next;
    logic signed [NW-1:0]  flip;
    // stage 5: per-group leading zeros
    logic [MW-1:0]         mg5_reg [3];
    logic [2:0]            neg5_reg;
    logic [GRPS-1:0]       nz_reg, nz_next;
    logic [GLZ_W-1:0]      glz_reg [GRPS], glz_next [GRPS];
    logic                  degen5_reg, degen5_next;
    logic [MW-1:0]         orv;
    logic [PADW-1:0]       pad;
    logic [GRP_W-1:0]      grp;
    // stage 6: shift count
    logic [MW-1:0]         mg6_reg [3];
    logic [2:0]            neg6_reg;
    logic                  degen6_reg;
    logic [LZW-1:0]        lz_reg, lz_next;
    // stage 7: normalized magnitudes
    norm_vec_t             a7_reg, a7_next;
    logic [2:0]            neg7_reg;
    logic                  degen7_reg;
    logic [MW-1:0]         shv;
    logic [MW+NORM_W-1:0]  ext;
    // stage 8: squares
    logic [2*NORM_W-1:0]   sq_reg [3], sq_next [3];
    norm_vec_t             a8_reg;
    logic [2:0]            neg8_reg;
    logic                  degen8_reg;
    // stage 9: sum of squares
    logic [SQ_W-1:0]       sum_reg, sum_next;
    norm_vec_t             a9_reg;
    logic [2:0]            neg9_reg;
    logic                  degen9_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d1 = $signed({pts[3+i][COORD_WIDTH-1], pts[3+i]})
               - $signed({pts[i][COORD_WIDTH-1], pts[i]});
            d2 = $signed({pts[6+i][COORD_WIDTH-1], pts[6+i]})
               - $signed({pts[i][COORD_WIDTH-1], pts[i]});
            // floor toward minus infinity on wide coordinates
            e1_next[i] = EW'(d1 >>> ESH);
            e2_next[i] = EW'(d2 >>> ESH);
        end
    end

    always_comb
    begin
        prod_next[0] = e1_reg[1] * e2_reg[2];
        prod_next[1] = e1_reg[2] * e2_reg[1];
        prod_next[2] = e1_reg[2] * e2_reg[0];
        prod_next[3] = e1_reg[0] * e2_reg[2];
        prod_next[4] = e1_reg[0] * e2_reg[1];
        prod_next[5] = e1_reg[1] * e2_reg[0];
        for (int i = 0; i < 3; i++)
        begin
            crs_next[i] = NW'(prod_reg[2*i]) - NW'(prod_reg[2*i+1]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            flip         = -crs_reg[i];
            neg4_next[i] = crs_reg[i][NW-1];
            mg4_next[i]  = neg4_next[i] ? flip[MW-1:0] : crs_reg[i][MW-1:0];
        end
    end

    // the bit length of the largest magnitude is the bit length of the OR
    always_comb
    begin
        orv         = mg4_reg[0] | mg4_reg[1] | mg4_reg[2];
        degen5_next = ~|orv;
        pad         = PADW'(orv) << (PADW - MW);
        for (int g = 0; g < GRPS; g++)
        begin
            grp         = pad[PADW-1-g*GRP_W -: GRP_W];
            nz_next[g]  = |grp;
            glz_next[g] = grp_lzc(grp);
        end
    end

    // first nonzero group from the top wins
    always_comb
    begin
        lz_next = '0;
        for (int g = GRPS - 1; g >= 0; g--)
        begin
            if (nz_reg[g])
            begin
                lz_next = LZW'(g * GRP_W) + LZW'(glz_reg[g]);
            end
        end
    end

    // top set bit lands on NORM_W-1; low bits drop on wide words
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            shv        = mg6_reg[i] << lz_reg;
            ext        = {shv, {NORM_W{1'b0}}};
            a7_next[i] = ext[MW+NORM_W-1 -: NORM_W];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_next[i] = a7_reg[i] * a7_reg[i];
        end
        sum_next = SQ_W'(sq_reg[0]) + SQ_W'(sq_reg[1]) + SQ_W'(sq_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], entry_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e1_reg[i]  <= e1_next[i];
                e2_reg[i]  <= e2_next[i];
                crs_reg[i] <= crs_next[i];
                mg4_reg[i] <= mg4_next[i];
                mg5_reg[i] <= mg4_reg[i];
                mg6_reg[i] <= mg5_reg[i];
                sq_reg[i]  <= sq_next[i];
            end
            for (int k = 0; k < 6; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
            for (int g = 0; g < GRPS; g++)
            begin
                glz_reg[g] <= glz_next[g];
            end
            nz_reg     <= nz_next;
            neg4_reg   <= neg4_next;
            neg5_reg   <= neg4_reg;
            neg6_reg   <= neg5_reg;
            neg7_reg   <= neg6_reg;
            neg8_reg   <= neg7_reg;
            neg9_reg   <= neg8_reg;
            degen5_reg <= degen5_next;
            degen6_reg <= degen5_reg;
            degen7_reg <= degen6_reg;
            degen8_reg <= degen7_reg;
            degen9_reg <= degen8_reg;
            lz_reg     <= lz_next;
            a7_reg     <= a7_next;
            a8_reg     <= a7_reg;
            a9_reg     <= a8_reg;
            sum_reg    <= sum_next;
        end
    end

    assign ctl.vld   = vld_reg[NSTG-1];
    assign ctl.degen = degen9_reg;
    assign ctl.neg   = neg9_reg;
    assign sum_sq    = sum_reg;
    assign mag       = a9_reg;

endmodule

// ----- rtl/core/tfn_sqrt.sv -----
module tfn_sqrt
    import tfn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  tfn_ctl_t          ctl_in,
    input  logic [SQ_W-1:0]   sum_sq,
    input  norm_vec_t         mag_in,
    output tfn_ctl_t          ctl_out,
    output logic [ROOT_W-1:0] root,
    output norm_vec_t         mag_out
);

    // one root bit per stage, two radicand bits consumed per stage
    logic [ROOT_W-1:0] vld_reg;
    logic [ROOT_W-1:0] degen_reg;
    logic [2:0]        neg_reg  [ROOT_W];
    norm_vec_t         a_reg    [ROOT_W];
    logic [SQ_W-1:0]   s_reg    [ROOT_W], s_next    [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W], rem_next  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W], root_next [ROOT_W];

    logic [SQ_W-1:0]   s_prv;
    logic [REM_W-1:0]  rem_prv;
    logic [ROOT_W-1:0] root_prv;
    logic [REM_W-1:0]  cur;
    logic [REM_W-1:0]  trial;

    always_comb
    begin
        for (int k = 0; k < ROOT_W; k++)
        begin
            if (k == 0)
            begin
                s_prv    = sum_sq;
                rem_prv  = '0;
                root_prv = '0;
            end
            else
            begin
                s_prv    = s_reg[k-1];
                rem_prv  = rem_reg[k-1];
                root_prv = root_reg[k-1];
            end
            cur   = {rem_prv[REM_W-3:0], s_prv[SQ_W-1 -: 2]};
            trial = REM_W'({root_prv, 2'b01});
            if (cur >= trial)
            begin
                rem_next[k]  = cur - trial;
                root_next[k] = {root_prv[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = cur;
                root_next[k] = {root_prv[ROOT_W-2:0], 1'b0};
            end
            s_next[k] = s_prv << 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[ROOT_W-2:0], ctl_in.vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < ROOT_W; k++)
            begin
                s_reg[k]    <= s_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
            a_reg[0]     <= mag_in;
            neg_reg[0]   <= ctl_in.neg;
            degen_reg[0] <= ctl_in.degen;
            for (int k = 1; k < ROOT_W; k++)
            begin
                a_reg[k]     <= a_reg[k-1];
                neg_reg[k]   <= neg_reg[k-1];
                degen_reg[k] <= degen_reg[k-1];
            end
        end
    end

    assign ctl_out.vld   = vld_reg[ROOT_W-1];
    assign ctl_out.degen = degen_reg[ROOT_W-1];
    assign ctl_out.neg   = neg_reg[ROOT_W-1];
    assign root          = root_reg[ROOT_W-1];
    assign mag_out       = a_reg[ROOT_W-1];

endmodule

// ----- rtl/core/tfn_div.sv -----
module tfn_div
    import tfn_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  tfn_ctl_t               ctl_in,
    input  logic [ROOT_W-1:0]      root,
    input  norm_vec_t              mag_in,
    output logic                   res_vld,
    output logic [2:0][UNIT_W-1:0] unit,
    output logic                   degen
);

    localparam int NSTG = QUO_W + 2;

    logic [NSTG-1:0] vld_reg;

    // setup stage: numerator (a << 15) + r, divisor 2r
    logic [2:0][NUM_W-1:0] num_reg, num_next;
    logic [D_W-1:0]        d0_reg;
    logic [2:0]            neg0_reg;
    logic                  degen0_reg;

    // one quotient bit per stage, three lanes
    logic [2:0][NUM_W-1:0] rem_reg [QUO_W], rem_next [QUO_W];
    logic [2:0][QUO_W-1:0] quo_reg [QUO_W], quo_next [QUO_W];
    logic [D_W-1:0]        d_reg   [QUO_W];
    logic [2:0]            neg_reg [QUO_W];
    logic [QUO_W-1:0]      degen_reg;

    // result stage
    logic [2:0][UNIT_W-1:0] unit_reg, unit_next;
    logic                   degen_f_reg;

    logic [2:0][NUM_W-1:0] rem_prv;
    logic [2:0][QUO_W-1:0] quo_prv;
    logic [D_W-1:0]        d_prv;
    logic [NUM_W-1:0]      dsh;
    logic [UNIT_W-1:0]     qext;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num_next[i] = {1'b0, mag_in[i], {FRAC_SH{1'b0}}} + NUM_W'(root);
        end
    end

    always_comb
    begin
        for (int k = 0; k < QUO_W; k++)
        begin
            if (k == 0)
            begin
                rem_prv = num_reg;
                quo_prv = '0;
                d_prv   = d0_reg;
            end
            else
            begin
                rem_prv = rem_reg[k-1];
                quo_prv = quo_reg[k-1];
                d_prv   = d_reg[k-1];
            end
            dsh = NUM_W'(d_prv) << (QUO_W - 1 - k);
            for (int i = 0; i < 3; i++)
            begin
                if (rem_prv[i] >= dsh)
                begin
                    rem_next[k][i] = rem_prv[i] - dsh;
                    quo_next[k][i] = {quo_prv[i][QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[k][i] = rem_prv[i];
                    quo_next[k][i] = {quo_prv[i][QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    // apply sign, force zero on a degenerate triangle
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qext = {1'b0, quo_reg[QUO_W-1][i]};
            if (degen_reg[QUO_W-1])
            begin
                unit_next[i] = '0;
            end
            else if (neg_reg[QUO_W-1][i])
            begin
                unit_next[i] = -qext;
            end
            else
            begin
                unit_next[i] = qext;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], ctl_in.vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg    <= num_next;
            d0_reg     <= {root, 1'b0};
            neg0_reg   <= ctl_in.neg;
            degen0_reg <= ctl_in.degen;
            for (int k = 0; k < QUO_W; k++)
            begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
            end
            d_reg[0]     <= d0_reg;
            neg_reg[0]   <= neg0_reg;
            degen_reg[0] <= degen0_reg;
            for (int k = 1; k < QUO_W; k++)
            begin
                d_reg[k]     <= d_reg[k-1];
                neg_reg[k]   <= neg_reg[k-1];
                degen_reg[k] <= degen_reg[k-1];
            end
            unit_reg    <= unit_next;
            degen_f_reg <= degen_reg[QUO_W-1];
        end
    end

    assign res_vld = vld_reg[NSTG-1];
    assign unit    = unit_reg;
    assign degen   = degen_f_reg;

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb
    import tfn_pkg::*;
();

    localparam int CW         = 16;
    localparam int EDGE_SH    = (CW > 29) ? (CW - 29) : 0;
    localparam int RAND_ITEMS = 1430;
    localparam int MN         = -(1 << (CW - 1));
    localparam int MX         = (1 << (CW - 1)) - 1;
    // Words handed to the block before the idle mix changes.
    localparam int PHASE1_AT  = 480;
    localparam int PHASE2_AT  = 960;
    // Word count at which the sender holds until the pipeline has drained.
    localparam int DRAIN_AT   = 720;
    // Cycles without any accepted word before the run is declared hung.
    localparam int HANG_LIMIT = 4000;
    // Pipeline depth plus margin for the final settle.
    localparam int SETTLE     = 70;

    typedef struct packed {
        logic signed [CW-1:0] ax, ay, az;
        logic signed [CW-1:0] bx, by, bz;
        logic signed [CW-1:0] cx, cy, cz;
    } triangle_t;

    typedef struct packed {
        logic signed [UNIT_W-1:0] ux, uy, uz;
        logic                     degen;
    } normal_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                 tri_valid  = 1'b0;
    logic                 tri_stall;
    logic signed [CW-1:0] a_x = '0, a_y = '0, a_z = '0;
    logic signed [CW-1:0] b_x = '0, b_y = '0, b_z = '0;
    logic signed [CW-1:0] c_x = '0, c_y = '0, c_z = '0;

    logic                     norm_valid;
    logic                     norm_stall = 1'b0;
    logic signed [UNIT_W-1:0] unit_x, unit_y, unit_z;
    logic                     degenerate;

    triangle_t pending_tris[$];
    normal_t   expected_normals[$];

    int  words_issued   = 0;
    int  normals_seen   = 0;
    int  degen_seen     = 0;
    int  fail_count     = 0;
    int  quiet_cycles   = 0;
    int  mix_phase      = 0;
    bit  drained        = 1'b0;
    bit  send_now;
    bit  drain_hold;
    triangle_t next_tri;
    triangle_t sent_tri;
    normal_t   want;
    normal_t   got;

    triangle_face_normal #(.COORD_WIDTH(CW)) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .tri_valid  (tri_valid),
        .tri_stall  (tri_stall),
        .a_x        (a_x),
        .a_y        (a_y),
        .a_z        (a_z),
        .b_x        (b_x),
        .b_y        (b_y),
        .b_z        (b_z),
        .c_x        (c_x),
        .c_y        (c_y),
        .c_z        (c_z),
        .norm_valid (norm_valid),
        .norm_stall (norm_stall),
        .unit_x     (unit_x),
        .unit_y     (unit_y),
        .unit_z     (unit_z),
        .degenerate (degenerate)
    );

    // Unit face normal of one triangle, in Q1.14, computed with 64-bit integers.
    function automatic normal_t face_normal(triangle_t t);
        longint          e1[3];
        longint          e2[3];
        longint          crs[3];
        longint unsigned mag[3];
        longint unsigned peak;
        longint unsigned sum_sq;
        longint unsigned root;
        longint unsigned trial;
        longint unsigned quo;
        int              len;
        normal_t         res;
        // Edges b - a and c - a; wide coordinates get a floor prescale.
        e1[0] = (longint'($signed(t.bx)) - longint'($signed(t.ax))) >>> EDGE_SH;
        e1[1] = (longint'($signed(t.by)) - longint'($signed(t.ay))) >>> EDGE_SH;
        e1[2] = (longint'($signed(t.bz)) - longint'($signed(t.az))) >>> EDGE_SH;
        e2[0] = (longint'($signed(t.cx)) - longint'($signed(t.ax))) >>> EDGE_SH;
        e2[1] = (longint'($signed(t.cy)) - longint'($signed(t.ay))) >>> EDGE_SH;
        e2[2] = (longint'($signed(t.cz)) - longint'($signed(t.az))) >>> EDGE_SH;
        crs[0] = e1[1] * e2[2] - e1[2] * e2[1];
        crs[1] = e1[2] * e2[0] - e1[0] * e2[2];
        crs[2] = e1[0] * e2[1] - e1[1] * e2[0];
        for (int i = 0; i < 3; i++)
            mag[i] = (crs[i] < 0) ? longint'(-crs[i]) : longint'(crs[i]);
        peak = mag[0];
        if (mag[1] > peak) peak = mag[1];
        if (mag[2] > peak) peak = mag[2];
        res = '0;
        if (peak == 0)
        begin
            res.degen = 1'b1;
            return res;
        end
        len = 0;
        for (int i = 0; i < 64; i++)
            if ((peak >> i) != 0) len = i + 1;
        // Bring the largest magnitude to exactly 30 bits.
        for (int i = 0; i < 3; i++)
            mag[i] = (len > 30) ? (mag[i] >> (len - 30)) : (mag[i] << (30 - len));
        sum_sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= sum_sq) root = trial;
        end
        for (int i = 0; i < 3; i++)
        begin
            quo = ((mag[i] << 15) + root) / (root << 1);
            if (crs[i] < 0) quo = -quo;
            case (i)
                0: res.ux = quo[UNIT_W-1:0];
                1: res.uy = quo[UNIT_W-1:0];
                default: res.uz = quo[UNIT_W-1:0];
            endcase
        end
        return res;
    endfunction

    task automatic queue_triangle(int ax, int ay, int az, int bx, int by, int bz,
                                  int cx, int cy, int cz);
        pending_tris.insert(pending_tris.size(),
                            {ax[CW-1:0], ay[CW-1:0], az[CW-1:0],
                             bx[CW-1:0], by[CW-1:0], bz[CW-1:0],
                             cx[CW-1:0], cy[CW-1:0], cz[CW-1:0]});
    endtask

    function automatic int pick_extreme();
        case ($urandom_range(4))
            0: return -(1 << (CW - 1));
            1: return -1;
            2: return 0;
            3: return 1;
            default: return (1 << (CW - 1)) - 1;
        endcase
    endfunction

    // Mostly full-range triangles, plus shapes that stress the degenerate
    // path, tiny cross products and the coordinate extremes.
    function automatic triangle_t random_triangle();
        int        kind;
        int        p[9];
        int        d[3];
        int        k;
        int        w;
        triangle_t t;
        kind = $urandom_range(99);
        for (int i = 0; i < 9; i++)
            p[i] = $signed(CW'($urandom));
        if (kind < 55)
        begin
            // keep the full-range draw
        end
        else if (kind < 70)
        begin
            for (int i = 0; i < 9; i++)
                p[i] = int'($urandom_range(16)) - 8;
        end
        else if (kind < 82)
        begin
            // Collinear: c lies on the line through a and b.
            k = int'($urandom_range(5)) - 2;
            for (int i = 0; i < 3; i++)
            begin
                p[i]     = int'($urandom_range(20000)) - 10000;
                d[i]     = int'($urandom_range(8000)) - 4000;
                p[3 + i] = p[i] + d[i];
                p[6 + i] = p[i] + k * d[i];
            end
        end
        else if (kind < 92)
        begin
            // Two coincident vertices.
            w = $urandom_range(2);
            for (int i = 0; i < 3; i++)
            begin
                if (w == 0) p[3 + i] = p[i];
                else if (w == 1) p[6 + i] = p[i];
                else p[6 + i] = p[3 + i];
            end
        end
        else
        begin
            for (int i = 0; i < 9; i++)
                p[i] = pick_extreme();
        end
        t = {p[0][CW-1:0], p[1][CW-1:0], p[2][CW-1:0],
             p[3][CW-1:0], p[4][CW-1:0], p[5][CW-1:0],
             p[6][CW-1:0], p[7][CW-1:0], p[8][CW-1:0]};
        return t;
    endfunction

    function automatic int sender_idle_pct(int ph);
        return (ph == 0) ? 23 : (ph == 1) ? 62 : 0;
    endfunction

    function automatic int receiver_idle_pct(int ph);
        return (ph == 0) ? 62 : (ph == 1) ? 23 : 0;
    endfunction

    // Free-running clock, 20 ns period.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Fill the stimulus queue while reset is held, release reset, then wait for the drain.
    initial
    begin
        // Directed words: extremes, axis-aligned faces, degenerate shapes.
        queue_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_triangle(MX, MX, MX, MX, MX, MX, MX, MX, MX);
        queue_triangle(MN, MN, MN, MN, MN, MN, MN, MN, MN);
        queue_triangle(0, 0, 0, 4096, 0, 0, 0, 4096, 0);
        queue_triangle(0, 0, 0, 0, 4096, 0, 4096, 0, 0);
        queue_triangle(0, 0, 0, 0, 4096, 0, 0, 0, 4096);
        queue_triangle(0, 0, 0, 0, 0, 4096, 4096, 0, 0);
        queue_triangle(0, 0, 0, 1, 0, 0, 0, 1, 0);
        queue_triangle(MN, MN, MN, MX, MN, MN, MN, MX, MN);
        queue_triangle(MX, MX, MX, MN, MX, MX, MX, MN, MX);
        queue_triangle(MN, MX, MN, MX, MN, MX, MN, MN, MX);
        queue_triangle(0, 0, 0, 1, 1, 1, 2, 2, 2);
        queue_triangle(MN, MN, MN, -1, -1, -1, MX, MX, MX);
        queue_triangle(0, 0, 0, 4096, -4096, 0, 0, 4096, -4096);
        queue_triangle(100, 200, 300, 100, 200, 300, 5, 6, 7);
        queue_triangle(-7, 9, 11, 300, -200, 100, 300, -200, 100);
        queue_triangle(0, 0, 0, 1, 2, 3, -3, 1, 2);
        queue_triangle(21845, 21845, 21845, -21846, 21845, -21846, 21845, -21846, -21846);
        queue_triangle(-1, -1, -1, 0, 0, 0, 1, -1, 1);
        queue_triangle(MX, 0, 0, 0, MX, 0, 0, 0, MX);
        for (int i = 0; i < RAND_ITEMS; i++)
            pending_tris.insert(pending_tris.size(), random_triangle());

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Advance until every word is handed over, then until every normal is back.
        while (pending_tris.size() != 0 || tri_valid) @(posedge clk);
        while (expected_normals.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (expected_normals.size() != 0)
        begin
            $error("%0d expected normals never arrived", expected_normals.size());
            fail_count++;
        end
        $display("Sent %0d triangles; checked %0d normals, %0d of them degenerate.",
                 words_issued, normals_seen, degen_seen);
        $display("Mixed sender/receiver idling in three phases with one full drain pause.");
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Driver: on each edge record an accepted word's prediction, then either
    // load the next word, drop valid to idle, or hold a stalled word.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tri_valid <= 1'b0;
        end
        else
        begin
            if (tri_valid && !tri_stall)
            begin
                sent_tri = {a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z};
                expected_normals.insert(expected_normals.size(), face_normal(sent_tri));
            end
            if (!tri_valid || !tri_stall)
            begin
                send_now = pending_tris.size() != 0 &&
                           $urandom_range(99) >= sender_idle_pct(mix_phase);
                // Hold off once mid-run until the pipeline has emptied.
                drain_hold = (words_issued == DRAIN_AT) && !drained;
                if (drain_hold && expected_normals.size() == 0)
                begin
                    drained    = 1'b1;
                    drain_hold = 1'b0;
                end
                if (send_now && !drain_hold)
                begin
                    next_tri = pending_tris.pop_front();
                    {a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} <= next_tri;
                    tri_valid <= 1'b1;
                    words_issued++;
                    mix_phase = (words_issued < PHASE1_AT) ? 0 :
                                (words_issued < PHASE2_AT) ? 1 : 2;
                end
                else
                begin
                    tri_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare every accepted normal word against the oldest prediction,
    // then draw this cycle's stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            norm_stall <= 1'b0;
        end
        else
        begin
            if (norm_valid && !norm_stall)
            begin
                got = {unit_x, unit_y, unit_z, degenerate};
                normals_seen++;
                if (degenerate) degen_seen++;
                if (expected_normals.size() == 0)
                begin
                    $error("normal word with no triangle pending: %0d %0d %0d degen %0b",
                           got.ux, got.uy, got.uz, got.degen);
                    fail_count++;
                end
                else
                begin
                    want = expected_normals.pop_front();
                    if (got.ux !== want.ux)
                    begin
                        $error("unit_x: expected %0d, got %0d", want.ux, got.ux);
                        fail_count++;
                    end
                    if (got.uy !== want.uy)
                    begin
                        $error("unit_y: expected %0d, got %0d", want.uy, got.uy);
                        fail_count++;
                    end
                    if (got.uz !== want.uz)
                    begin
                        $error("unit_z: expected %0d, got %0d", want.uz, got.uz);
                        fail_count++;
                    end
                    if (got.degen !== want.degen)
                    begin
                        $error("degenerate: expected %0b, got %0b", want.degen, got.degen);
                        fail_count++;
                    end
                end
            end
            norm_stall <= ($urandom_range(99) < receiver_idle_pct(mix_phase));
        end
    end

    // Watchdog: count cycles in which neither side accepts a word.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((tri_valid && !tri_stall) || (norm_valid && !norm_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("Timeout: no word accepted for %0d cycles.", HANG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

endmodule
